[rtl/ilid_pkg.sv]
// Shared types and constants for the indexed list engine.
// Used by ilid_cell and indexed_list_insert_delete; depends on nothing.
`default_nettype none

package ilid_pkg;

  localparam int LIST_DEPTH_DEF = 1024;
  localparam int POS_W          = 11;
  localparam int VAL_W          = 32;

  typedef logic [1:0] op_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_APPEND = 2'd2;
  localparam op_t OP_READ   = 2'd3;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    op_t                      operation;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  item_value;
  } in_beat_t;

  typedef struct packed {
    logic                     status;
    logic signed [VAL_W-1:0]  read_value;
    logic [POS_W-1:0]         list_length;
  } out_beat_t;

  // Broadcast to every cell; the cell's own index decides what it does.
  typedef struct packed {
    logic              wr;
    logic              ins;
    logic              rd_load;
    logic              rd_shift;
    logic [VAL_W-1:0]  value;
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/ilid_cell.sv]
// One list cell: holds one entry and one read-chain stage.
// Depends on ilid_pkg; instantiated in a row by indexed_list_insert_delete.
`default_nettype none

module ilid_cell #(
  parameter int CNT_W = 11,
  parameter int IDX   = 0
) (
  input  logic                     clk,
  input  ilid_pkg::cell_cmd_t      cmd,
  input  logic [CNT_W-1:0]         k,
  input  logic [ilid_pkg::VAL_W-1:0] left_entry,
  input  logic [ilid_pkg::VAL_W-1:0] right_entry,
  input  logic [ilid_pkg::VAL_W-1:0] right_rd,
  output logic [ilid_pkg::VAL_W-1:0] entry,
  output logic [ilid_pkg::VAL_W-1:0] rd
);
  import ilid_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [VAL_W-1:0] entry_r, entry_nxt;
  logic [VAL_W-1:0] rd_r, rd_nxt;
  logic             at_k;
  logic             past_k;

  assign at_k   = (MY_IDX == k);
  assign past_k = (MY_IDX > k);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.wr) begin
      if (cmd.ins) begin
        if (at_k) begin
          entry_nxt = cmd.value;
        end else if (past_k) begin
          entry_nxt = left_entry;
        end
      end else if (at_k || past_k) begin
        entry_nxt = right_entry;
      end
    end
  end

  always_comb begin
    rd_nxt = rd_r;
    if (cmd.rd_load) begin
      rd_nxt = entry_r;
    end else if (cmd.rd_shift) begin
      rd_nxt = right_rd;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    rd_r    <= rd_nxt;
  end

  assign entry = entry_r;
  assign rd    = rd_r;

endmodule

`default_nettype wire

[rtl/indexed_list_insert_delete.sv]
// Top level of the indexed list engine: command decode, length count, result
// register and a row of ilid_cell instances. Depends on ilid_pkg, ilid_cell.
//
// Usage: drive in_beat and raise start; the beat is taken at a rising edge with
// start high and busy low. Each beat gives exactly one result, shown on
// out_beat for one cycle while out_valid is high; the receiver cannot stall.
// Insert, delete and append shift every cell in parallel: the result appears
// the cycle after the beat and busy stays low, so one such beat per cycle is
// taken. A failed read behaves the same way.
// A successful read at position p loads the read chain of the cells and moves
// it one cell toward the head per cycle until the entry reaches the first
// cell: busy stays high for the whole walk, and the result is registered from
// the first cell when it ends. Throughput is set by the length of the walk.
// Positions are 1-based and unused by append. Out-of-range positions, insert
// or append to a full list and delete from an empty list leave the list
// unchanged with status 1. Reset clears the length and the control state;
// cell contents are left as they are and are never read before being written.
`default_nettype none

module indexed_list_insert_delete #(
  parameter int LIST_DEPTH = ilid_pkg::LIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ilid_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  output ilid_pkg::out_beat_t out_beat
);
  import ilid_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_READ = 1'b1;

  logic [0:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rcnt_r, rcnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_beat_r, out_beat_nxt;

  cell_cmd_t        cmd;
  logic [CNT_W-1:0] k;
  logic             accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             pos_ok;
  logic             full;
  logic [CNT_W-1:0] pos_m1;

  logic [VAL_W-1:0] ent [LIST_DEPTH];
  logic [VAL_W-1:0] rdv [LIST_DEPTH];

  assign busy    = (state_r == ST_READ);
  assign accept  = start && !busy;
  assign pos_ext = CMP_W'(in_beat.position);
  assign cnt_ext = CMP_W'(count_r);
  assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign full    = (count_r == CNT_W'(LIST_DEPTH));
  assign pos_m1  = CNT_W'(pos_ext - CMP_W'(1));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rcnt_nxt      = rcnt_r;
    out_valid_nxt = 1'b0;
    out_beat_nxt  = out_beat_r;
    cmd           = '0;
    cmd.value     = in_beat.item_value;
    k             = pos_m1;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt           = 1'b1;
          out_beat_nxt.status     = STATUS_ERR;
          out_beat_nxt.read_value = '0;
          unique case (in_beat.operation)
            OP_INSERT: begin
              if (!full && pos_ok) begin
                cmd.wr                  = 1'b1;
                cmd.ins                 = 1'b1;
                count_nxt               = count_r + CNT_W'(1);
                out_beat_nxt.status     = STATUS_OK;
              end
            end
            OP_DELETE: begin
              if (pos_ok) begin
                cmd.wr                  = 1'b1;
                count_nxt               = count_r - CNT_W'(1);
                out_beat_nxt.status     = STATUS_OK;
              end
            end
            OP_APPEND: begin
              k = count_r;
              if (!full) begin
                cmd.wr                  = 1'b1;
                cmd.ins                 = 1'b1;
                count_nxt               = count_r + CNT_W'(1);
                out_beat_nxt.status     = STATUS_OK;
              end
            end
            OP_READ: begin
              if (pos_ok) begin
                cmd.rd_load   = 1'b1;
                rcnt_nxt      = pos_m1;
                state_nxt     = ST_READ;
                out_valid_nxt = 1'b0;
              end
            end
          endcase
          out_beat_nxt.list_length = POS_W'(count_nxt);
        end
      end
      ST_READ: begin
        if (rcnt_r == '0) begin
          out_valid_nxt            = 1'b1;
          out_beat_nxt.status      = STATUS_OK;
          out_beat_nxt.read_value  = rdv[0];
          out_beat_nxt.list_length = POS_W'(count_r);
          state_nxt                = ST_IDLE;
        end else begin
          cmd.rd_shift = 1'b1;
          rcnt_nxt     = rcnt_r - CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rcnt_r      <= rcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_e;
    logic [VAL_W-1:0] right_e;
    logic [VAL_W-1:0] right_r;

    if (i == 0) begin : g_head
      assign left_e = '0;
    end else begin : g_mid
      assign left_e = ent[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign right_e = '0;
      assign right_r = '0;
    end else begin : g_body
      assign right_e = ent[i+1];
      assign right_r = rdv[i+1];
    end

    ilid_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .k           (k),
      .left_entry  (left_e),
      .right_entry (right_e),
      .right_rd    (right_r),
      .entry       (ent[i]),
      .rd          (rdv[i])
    );
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("list length beyond depth");

  a_quick_result : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_beat.operation != OP_READ) |=> out_valid)
    else $error("missing result after list update");

  a_read_done : assert property (@(posedge clk) disable iff (!rst_n)
    (busy && rcnt_r == '0) |=> (out_valid && !busy))
    else $error("read walk did not finish");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.status == STATUS_ERR) |-> (out_beat.read_value == '0))
    else $error("error result carries data");

  a_busy_silent : assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> !out_valid)
    else $error("result during read walk");

endmodule

`default_nettype wire
